### src/rtia_pkg.sv
// ray/triangle intersect: shared types, codes and fixed-point helpers
// no dependencies; compiled first
package rtia_pkg;

  typedef logic signed [31:0] q16_t;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RAY  = 1'b1;

  // triangle vector select codes
  localparam logic [1:0] VEC_VERTEX = 2'd0;
  localparam logic [1:0] VEC_NORMAL = 2'd1;
  localparam logic [1:0] VEC_DUAL1  = 2'd2;
  localparam logic [1:0] VEC_DUAL2  = 2'd3;

  // accumulator, saturation and divider widths, divider steps and t limit
  localparam int ACC_W = 52;
  localparam int SAT_W = 53;
  localparam int DIV_W = 53;
  localparam int DIV_STEPS = 31;
  localparam logic [30:0] T_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    logic       req_type;
    logic [1:0] vec_sel;
    q16_t       ax;
    q16_t       ay;
    q16_t       az;
    q16_t       dir_x;
    q16_t       dir_y;
    q16_t       dir_z;
  } item_t;

  typedef struct packed {
    logic hit;
    q16_t hit_t;
    q16_t point_x;
    q16_t point_y;
    q16_t point_z;
    q16_t normal_x;
    q16_t normal_y;
    q16_t normal_z;
    q16_t coord_u;
    q16_t coord_w;
  } result_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic q16_t sat32(input logic signed [SAT_W-1:0] x);
    if (x[SAT_W-1:31] == {(SAT_W-31){x[SAT_W-1]}}) begin
      return x[31:0];
    end
    return {x[SAT_W-1], {31{~x[SAT_W-1]}}};
  endfunction

endpackage

### src/rtia_if.sv
// ray/triangle intersect: input and result channel interfaces
// valid/ready handshake with the word fields; no dependencies
interface rtia_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [1:0]         vec_sel;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] az;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;

  modport source (output valid, req_type, vec_sel, ax, ay, az, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, req_type, vec_sel, ax, ay, az, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rtia_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] hit_t;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic signed [31:0] coord_u;
  logic signed [31:0] coord_w;

  modport source (output valid, hit, hit_t, point_x, point_y, point_z,
                  normal_x, normal_y, normal_z, coord_u, coord_w, input ready);
  modport sink (input valid, hit, hit_t, point_x, point_y, point_z,
                normal_x, normal_y, normal_z, coord_u, coord_w, output ready);
endinterface

### src/rtia_front.sv
// ray/triangle intersect front end: accepts words and queues them in order
// depends on rtia_pkg and rtia_in_if
module rtia_front import rtia_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  rtia_in_if.sink   in_ch,
  output logic      q_valid,
  output item_t     q_item,
  input  logic      q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           push;
  item_t          in_item;

  // pack the incoming word
  always_comb begin
    in_item.req_type = in_ch.req_type;
    in_item.vec_sel  = in_ch.vec_sel;
    in_item.ax       = in_ch.ax;
    in_item.ay       = in_ch.ay;
    in_item.az       = in_ch.az;
    in_item.dir_x    = in_ch.dir_x;
    in_item.dir_y    = in_ch.dir_y;
    in_item.dir_z    = in_ch.dir_z;
  end

  assign in_ch.ready = (count_r != CW'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_item      = mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(q_pop);
    end
  end

endmodule

### src/rtia_back.sv
// ray/triangle intersect back end: triangle store, shared multiplier,
// restoring divider and result register; depends on rtia_pkg, rtia_out_if
module rtia_back import rtia_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  rtia_out_if.source  out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DOT  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_EDGE = 3'd5;
  localparam logic [2:0] S_EVAL = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]              state_r;
  logic [4:0]              cnt_r;
  q16_t                    vertex_r [3];
  q16_t                    normal_r [3];
  q16_t                    dual1_r [3];
  q16_t                    dual2_r [3];
  q16_t                    o_r [3];
  q16_t                    d_r [3];
  logic signed [32:0]      pq_r [3];
  q16_t                    qv_r [3];
  q16_t                    pt_r [3];
  logic signed [ACC_W-1:0] a_r;
  logic signed [ACC_W-1:0] b_r;
  logic signed [ACC_W-1:0] u_r;
  logic signed [ACC_W-1:0] w_r;
  logic [DIV_W-1:0]        rem_r;
  logic [DIV_W-1:0]        ma_r;
  logic [30:0]             nbits_r;
  logic [30:0]             t_r;
  result_t                 pend_r;
  result_t                 res_r;
  logic                    out_valid_r;

  logic [1:0]              idx;
  logic signed [32:0]      mul_x;
  logic signed [32:0]      mul_y;
  logic signed [65:0]      prod;
  logic signed [65:0]      prod_sh;
  logic signed [ACC_W-1:0] fl;
  logic [ACC_W-1:0]        ma;
  logic [ACC_W-1:0]        mb;
  logic                    t_ovf;
  logic [DIV_W-1:0]        r2;
  logic signed [SAT_W-1:0] uw;
  logic                    can_load;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign can_load = !out_valid_r || out_ch.ready;

  // shared multiplier operand select
  always_comb begin
    idx   = (state_r == S_STEP) ? cnt_r[1:0] : cnt_r[2:1];
    mul_x = '0;
    mul_y = '0;
    unique case (state_r)
      S_DOT: begin
        mul_x = cnt_r[0] ? pq_r[idx] : 33'(d_r[idx]);
        mul_y = 33'(normal_r[idx]);
      end
      S_STEP: begin
        mul_x = {2'b00, t_r};
        mul_y = 33'(d_r[idx]);
      end
      S_EDGE: begin
        mul_x = cnt_r[0] ? 33'(dual2_r[idx]) : 33'(dual1_r[idx]);
        mul_y = 33'(qv_r[idx]);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    prod    = mul_x * mul_y;
    prod_sh = prod >>> 16;
    fl      = prod_sh[ACC_W-1:0];
  end

  // magnitudes, overflow test, divider step and u+w sum
  always_comb begin
    ma    = a_r[ACC_W-1] ? ACC_W'(-a_r) : ACC_W'(a_r);
    mb    = b_r[ACC_W-1] ? ACC_W'(-b_r) : ACC_W'(b_r);
    t_ovf = {15'b0, mb} >= {ma, 15'b0};
    r2    = {rem_r[DIV_W-2:0], nbits_r[30]};
    uw    = SAT_W'(u_r) + SAT_W'(w_r);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        vertex_r[i] <= '0;
        normal_r[i] <= '0;
        dual1_r[i]  <= '0;
        dual2_r[i]  <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.req_type == REQ_LOAD) begin
              unique case (q_item.vec_sel)
                VEC_VERTEX: begin
                  vertex_r[0] <= q_item.ax;
                  vertex_r[1] <= q_item.ay;
                  vertex_r[2] <= q_item.az;
                end
                VEC_NORMAL: begin
                  normal_r[0] <= q_item.ax;
                  normal_r[1] <= q_item.ay;
                  normal_r[2] <= q_item.az;
                end
                VEC_DUAL1: begin
                  dual1_r[0] <= q_item.ax;
                  dual1_r[1] <= q_item.ay;
                  dual1_r[2] <= q_item.az;
                end
                default: begin
                  dual2_r[0] <= q_item.ax;
                  dual2_r[1] <= q_item.ay;
                  dual2_r[2] <= q_item.az;
                end
              endcase
            end else begin
              o_r[0] <= q_item.ax;
              o_r[1] <= q_item.ay;
              o_r[2] <= q_item.az;
              d_r[0] <= q_item.dir_x;
              d_r[1] <= q_item.dir_y;
              d_r[2] <= q_item.dir_z;
              pq_r[0] <= 33'(vertex_r[0]) - 33'(q_item.ax);
              pq_r[1] <= 33'(vertex_r[1]) - 33'(q_item.ay);
              pq_r[2] <= 33'(vertex_r[2]) - 33'(q_item.az);
              a_r     <= '0;
              b_r     <= '0;
              u_r     <= '0;
              w_r     <= '0;
              pend_r  <= '0;
              cnt_r   <= '0;
              state_r <= S_DOT;
            end
          end
        end
        // a = d.n on even steps, b = (p0-o).n on odd steps
        S_DOT: begin
          if (cnt_r[0]) begin
            b_r <= b_r + fl;
          end else begin
            a_r <= a_r + fl;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd5) begin
            state_r <= S_CHK;
          end
        end
        // parallel or wrong side is a miss; t saturates on overflow, else divide
        S_CHK: begin
          cnt_r <= '0;
          if (a_r == '0 || b_r == '0 || (a_r[ACC_W-1] != b_r[ACC_W-1])) begin
            state_r <= S_OUT;
          end else if (t_ovf) begin
            t_r     <= T_MAX;
            state_r <= S_STEP;
          end else begin
            ma_r    <= DIV_W'(ma);
            rem_r   <= DIV_W'(mb >> 15);
            nbits_r <= {mb[14:0], 16'b0};
            t_r     <= '0;
            state_r <= S_DIV;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (r2 >= ma_r) begin
            rem_r <= r2 - ma_r;
            t_r   <= {t_r[29:0], 1'b1};
          end else begin
            rem_r <= r2;
            t_r   <= {t_r[29:0], 1'b0};
          end
          nbits_r <= {nbits_r[29:0], 1'b0};
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == 5'(DIV_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_STEP;
          end
        end
        // q = p0-o-t*d and hit point o+t*d, one axis per cycle; a t of zero is a miss
        S_STEP: begin
          if (t_r == '0) begin
            state_r <= S_OUT;
          end else begin
            qv_r[idx] <= sat32(SAT_W'(pq_r[idx]) - SAT_W'(fl));
            pt_r[idx] <= sat32(SAT_W'(o_r[idx]) + SAT_W'(fl));
            cnt_r     <= cnt_r + 1'b1;
            if (cnt_r == 5'd2) begin
              cnt_r   <= '0;
              state_r <= S_EDGE;
            end
          end
        end
        // u = a1.q on even steps, w = a2.q on odd steps
        S_EDGE: begin
          if (cnt_r[0]) begin
            w_r <= w_r + fl;
          end else begin
            u_r <= u_r + fl;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd5) begin
            state_r <= S_EVAL;
          end
        end
        // inside test
        S_EVAL: begin
          if (u_r[ACC_W-1] && w_r[ACC_W-1] && (uw > -SAT_W'(65536))) begin
            pend_r.hit      <= 1'b1;
            pend_r.hit_t    <= {1'b0, t_r};
            pend_r.point_x  <= pt_r[0];
            pend_r.point_y  <= pt_r[1];
            pend_r.point_z  <= pt_r[2];
            pend_r.normal_x <= normal_r[0];
            pend_r.normal_y <= normal_r[1];
            pend_r.normal_z <= normal_r[2];
            pend_r.coord_u  <= sat32(SAT_W'(u_r));
            pend_r.coord_w  <= sat32(SAT_W'(w_r));
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (can_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && can_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && can_load) begin
      res_r <= pend_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.hit      = res_r.hit;
  assign out_ch.hit_t    = res_r.hit_t;
  assign out_ch.point_x  = res_r.point_x;
  assign out_ch.point_y  = res_r.point_y;
  assign out_ch.point_z  = res_r.point_z;
  assign out_ch.normal_x = res_r.normal_x;
  assign out_ch.normal_y = res_r.normal_y;
  assign out_ch.normal_z = res_r.normal_z;
  assign out_ch.coord_u  = res_r.coord_u;
  assign out_ch.coord_w  = res_r.coord_w;

endmodule

### src/ray_triangle_intersect_unit.sv
// ray/triangle intersect top: front queue feeding the sequenced back end
// a ray word is tested on the shared 33x33 multiplier and the restoring
// divider in turn: dot products, division, point, edges and inside test
// rays are tested one at a time while the queue takes further words;
// load words are taken one per cycle while the back end is idle
// reset: synchronous active low; clears the queue, the triangle to zero
// and the result valid flag
module ray_triangle_intersect_unit import rtia_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  rtia_in_if.sink     in_ch,
  rtia_out_if.source  out_ch
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // accept and queue words
  rtia_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // triangle store and ray test
  rtia_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### src/rtia_checker.sv
// ray/triangle intersect port checker and its bind to the top level
// depends on ray_triangle_intersect_unit ports only
module rtia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [31:0] hit_t,
  input logic [31:0] coord_u,
  input logic [31:0] coord_w,
  input logic [31:0] point_x
);

  // result hit flag and t hold while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hit_t) && $stable(hit))
    else $error("result word dropped or changed while stalled");

  // a miss carries zero t, edge coordinates and point_x
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> hit_t == '0 && coord_u == '0 && coord_w == '0 &&
    point_x == '0)
    else $error("miss word carries nonzero fields");

  // a hit has positive t and negative edge coordinates
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit |-> !hit_t[31] && hit_t != '0 && coord_u[31] && coord_w[31])
    else $error("hit word out of range");

  // nothing is shown right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_triangle_intersect_unit rtia_checker u_rtia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .hit       (out_ch.hit),
  .hit_t     (out_ch.hit_t),
  .coord_u   (out_ch.coord_u),
  .coord_w   (out_ch.coord_w),
  .point_x   (out_ch.point_x)
);
